@@ rtl/core/teq_pkg.sv @@
// Shared types and constants for the timed event queue.
`timescale 1ns / 1ps
`default_nettype none

package teq_pkg;

   localparam int TIME_WIDTH      = 32;
   localparam int HANDLE_WIDTH    = 16;
   localparam int OCC_WIDTH       = 5;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int REQ_DATA_WIDTH  = 80;
   localparam int RSP_DATA_WIDTH  = 24;
   localparam int RSP_USER_WIDTH  = 2;

   typedef enum logic {
      MODE_ADD  = 1'b0,
      MODE_POLL = 1'b1
   } mode_type;

   typedef struct packed {
      logic                    add;
      logic                    pop;
      logic [TIME_WIDTH-1:0]   due;
      logic [HANDLE_WIDTH-1:0] handle;
   } ctl_type;

endpackage

`default_nettype wire

@@ rtl/core/teq_cell.sv @@
// One slot of the sorted queue: holds, takes the new event, or shifts with its neighbors.
`timescale 1ns / 1ps
`default_nettype none

module teq_cell (
   input  wire logic                             clock,
   input  wire logic                             valid,
   input  wire teq_pkg::ctl_type                 ctl,
   input  wire logic                             left_keep,
   input  wire logic [teq_pkg::TIME_WIDTH-1:0]   left_time,
   input  wire logic [teq_pkg::HANDLE_WIDTH-1:0] left_handle,
   input  wire logic [teq_pkg::TIME_WIDTH-1:0]   right_time,
   input  wire logic [teq_pkg::HANDLE_WIDTH-1:0] right_handle,
   output logic                                  keep,
   output logic [teq_pkg::TIME_WIDTH-1:0]        slot_time,
   output logic [teq_pkg::HANDLE_WIDTH-1:0]      slot_handle
);
   import teq_pkg::*;

   logic [TIME_WIDTH-1:0]   time_ff;
   logic [TIME_WIDTH-1:0]   time_in;
   logic [HANDLE_WIDTH-1:0] handle_ff;
   logic [HANDLE_WIDTH-1:0] handle_in;

   assign keep        = valid && (time_ff <= ctl.due);
   assign slot_time   = time_ff;
   assign slot_handle = handle_ff;

   always_comb begin
      time_in   = time_ff;
      handle_in = handle_ff;
      if (ctl.add && !keep) begin
         if (left_keep) begin
            time_in   = ctl.due;
            handle_in = ctl.handle;
         end else begin
            time_in   = left_time;
            handle_in = left_handle;
         end
      end else if (ctl.pop) begin
         time_in   = right_time;
         handle_in = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      time_ff   <= time_in;
      handle_ff <= handle_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/timed_event_queue.sv @@
// Top level of the timed event queue: a row of sorted slots, an entry count and a result register.
`timescale 1ns / 1ps
`default_nettype none

// The queue keeps up to QUEUE_DEPTH events sorted by due time in a row of slot cells that
// all compare against the incoming beat at once, so a new request beat is taken in every
// cycle while the result register is free or being drained. An add inserts after all
// entries with an equal or earlier due time, so equal times leave in arrival order; an add
// to a full queue is dropped and flagged as overflow. A poll pops the head when its due
// time is not later than the given tick. Every request beat gives exactly one response
// beat, which also reports the occupancy after the request.
module timed_event_queue #(
   parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // due_time [31:0], event_handle [47:32], now [79:48]
   input  wire logic [teq_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // mode [0]
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // ready_handle [15:0], occupancy [20:16], zero [23:21]
   output logic [teq_pkg::RSP_DATA_WIDTH-1:0]        rsp_tdata,
   // ready_res [0], overflow [1]
   output logic [teq_pkg::RSP_USER_WIDTH-1:0]        rsp_tuser
);
   import teq_pkg::*;

   localparam int CountWidth = $clog2(QUEUE_DEPTH + 1);

   logic [TIME_WIDTH-1:0]   req_due;
   logic [HANDLE_WIDTH-1:0] req_handle;
   logic [TIME_WIDTH-1:0]   req_now;
   logic                    accept;
   logic                    full;
   logic                    head_due;
   ctl_type                 ctl;

   logic [CountWidth-1:0]   count_ff;
   logic [CountWidth-1:0]   count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic                    ready_res_ff;
   logic                    ready_res_in;
   logic                    overflow_ff;
   logic                    overflow_in;
   logic [HANDLE_WIDTH-1:0] ready_handle_ff;
   logic [HANDLE_WIDTH-1:0] ready_handle_in;
   logic [OCC_WIDTH-1:0]    occupancy_ff;
   logic [OCC_WIDTH-1:0]    occupancy_in;

   logic                    keep_w   [QUEUE_DEPTH];
   logic [TIME_WIDTH-1:0]   time_w   [QUEUE_DEPTH];
   logic [HANDLE_WIDTH-1:0] handle_w [QUEUE_DEPTH];

   assign req_due    = req_tdata[31:0];
   assign req_handle = req_tdata[47:32];
   assign req_now    = req_tdata[79:48];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign head_due   = (count_ff != '0) && (time_w[0] <= req_now);

   assign ctl.add    = accept && (req_tuser == MODE_ADD) && !full;
   assign ctl.pop    = accept && (req_tuser == MODE_POLL) && head_due;
   assign ctl.due    = req_due;
   assign ctl.handle = req_handle;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                    cell_valid;
      logic                    l_keep;
      logic [TIME_WIDTH-1:0]   l_time;
      logic [HANDLE_WIDTH-1:0] l_handle;
      logic [TIME_WIDTH-1:0]   r_time;
      logic [HANDLE_WIDTH-1:0] r_handle;

      assign cell_valid = (CountWidth'(i) < count_ff);

      if (i == 0) begin : g_first
         assign l_keep   = 1'b1;
         assign l_time   = req_due;
         assign l_handle = req_handle;
      end else begin : g_inner
         assign l_keep   = keep_w[i-1];
         assign l_time   = time_w[i-1];
         assign l_handle = handle_w[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign r_time   = time_w[i];
         assign r_handle = handle_w[i];
      end else begin : g_body
         assign r_time   = time_w[i+1];
         assign r_handle = handle_w[i+1];
      end

      teq_cell u_cell (
         .clock        (clock),
         .valid        (cell_valid),
         .ctl          (ctl),
         .left_keep    (l_keep),
         .left_time    (l_time),
         .left_handle  (l_handle),
         .right_time   (r_time),
         .right_handle (r_handle),
         .keep         (keep_w[i]),
         .slot_time    (time_w[i]),
         .slot_handle  (handle_w[i])
      );
   end

   always_comb begin
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff;
      ready_res_in    = ready_res_ff;
      overflow_in     = overflow_ff;
      ready_handle_in = ready_handle_ff;
      occupancy_in    = occupancy_ff;
      if (ctl.add) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in    = 1'b1;
         ready_res_in    = ctl.pop;
         overflow_in     = (req_tuser == MODE_ADD) && full;
         ready_handle_in = ctl.pop ? handle_w[0] : '0;
         occupancy_in    = OCC_WIDTH'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ready_res_ff    <= ready_res_in;
      overflow_ff     <= overflow_in;
      ready_handle_ff <= ready_handle_in;
      occupancy_ff    <= occupancy_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, occupancy_ff, ready_handle_ff};
   assign rsp_tuser  = {overflow_ff, ready_res_ff};

endmodule

`default_nettype wire
